FILE: sv/dpcd_pkg.sv
// ----------------------------------------------------------------------------
// dpcd_pkg
// Types and constants shared by the delta patch command decoder.
// ----------------------------------------------------------------------------
package dpcd_pkg;

  localparam int COUNT_WIDTH = 64;
  localparam logic [63:0] COUNT_MAX = 64'((65'd1 << COUNT_WIDTH) - 65'd1);

  localparam logic [31:0] MAGIC_WORD = 32'h7273_0236;
  localparam logic [7:0]  CMD_END    = 8'h00;
  localparam logic [7:0]  LIT_FIRST  = 8'h41;
  localparam logic [7:0]  LIT_LAST   = 8'h44;
  localparam logic [7:0]  COPY_FIRST = 8'h45;
  localparam logic [7:0]  COPY_LAST  = 8'h54;

  // width code of a magic word: four bytes
  localparam logic [1:0]  MAGIC_WCODE = 2'd2;

  typedef enum logic [1:0] {
    KIND_LITERAL = 2'd0,
    KIND_COPY    = 2'd1,
    KIND_END     = 2'd2,
    KIND_ERROR   = 2'd3
  } kind_t;

  typedef enum logic {
    ERR_BAD_MAGIC = 1'b0,
    ERR_BAD_CMD   = 1'b1
  } err_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  literal_byte;
    logic        literal_last;
    logic [63:0] copy_offset;
    logic [63:0] copy_length;
    err_t        error_code;
  } result_t;

endpackage

FILE: sv/dpcd_if.sv
// ----------------------------------------------------------------------------
// dpcd interfaces
// Valid/ready channels for patch bytes in and decoded items out.
// ----------------------------------------------------------------------------
interface dpcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] patch_byte;

  modport source (output valid, output patch_byte, input ready);
  modport sink   (input valid, input patch_byte, output ready);
endinterface

interface dpcd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  literal_byte;
  logic        literal_last;
  logic [63:0] copy_offset;
  logic [63:0] copy_length;
  logic        error_code;

  modport source (output valid, output kind, output literal_byte, output literal_last,
                  output copy_offset, output copy_length, output error_code,
                  input ready);
  modport sink   (input valid, input kind, input literal_byte, input literal_last,
                  input copy_offset, input copy_length, input error_code,
                  output ready);
endinterface

FILE: sv/dpcd_in_reg.sv
// ----------------------------------------------------------------------------
// dpcd_in_reg
// Input register for patch bytes; refills in the cycle it is drained.
// ----------------------------------------------------------------------------
module dpcd_in_reg (
  input  logic       clk,
  input  logic       rst_n,
  dpcd_in_if.sink    in_ch,
  input  logic       advance,
  output logic       byte_valid,
  output logic [7:0] byte_data
);

  logic       valid_r;
  logic [7:0] data_r;

  assign in_ch.ready = !valid_r || advance;
  assign byte_valid  = valid_r;
  assign byte_data   = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      data_r <= in_ch.patch_byte;
    end
  end

endmodule

FILE: sv/dpcd_decode.sv
// ----------------------------------------------------------------------------
// dpcd_decode
// Command decoder: magic check, field assembly and result formation.
// ----------------------------------------------------------------------------
module dpcd_decode (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [7:0]        byte_data,
  output logic              res_valid,
  output dpcd_pkg::result_t res
);
  import dpcd_pkg::*;

  typedef enum logic [2:0] {
    PH_MAGIC   = 3'd0,
    PH_CMD     = 3'd1,
    PH_LITLEN  = 3'd2,
    PH_LITDATA = 3'd3,
    PH_COPYOFF = 3'd4,
    PH_COPYLEN = 3'd5
  } phase_t;

  phase_t                 phase_r, phase_nxt;
  logic [2:0]             idx_r, idx_nxt;
  logic [1:0]             owc_r, owc_nxt;
  logic [1:0]             lwc_r, lwc_nxt;
  logic [63:0]            acc_r, acc_nxt;
  logic [63:0]            held_r, held_nxt;
  logic [COUNT_WIDTH-1:0] rem_r, rem_nxt;

  logic [63:0] acc_sh;
  logic [63:0] lit_len;
  logic [7:0]  copy_code;
  logic        rem_last;

  function automatic logic field_done(input logic [2:0] idx, input logic [1:0] code);
    return ({1'b0, idx} + 4'd1) >= (4'd1 << code);
  endfunction

  assign acc_sh    = {acc_r[55:0], byte_data};
  assign lit_len   = (acc_sh > COUNT_MAX) ? COUNT_MAX : acc_sh;
  assign copy_code = byte_data - COPY_FIRST;
  assign rem_last  = rem_r <= COUNT_WIDTH'(1);

  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    owc_nxt   = owc_r;
    lwc_nxt   = lwc_r;
    acc_nxt   = acc_r;
    held_nxt  = held_r;
    rem_nxt   = rem_r;
    res_valid = 1'b0;
    res       = '0;
    if (fire) begin
      unique case (phase_r)
        PH_CMD: begin
          idx_nxt = 3'd0;
          acc_nxt = '0;
          if (byte_data == CMD_END) begin
            res_valid = 1'b1;
            res.kind  = KIND_END;
            phase_nxt = PH_MAGIC;
          end else if (byte_data inside {[LIT_FIRST:LIT_LAST]}) begin
            lwc_nxt   = 2'(byte_data - LIT_FIRST);
            phase_nxt = PH_LITLEN;
          end else if (byte_data inside {[COPY_FIRST:COPY_LAST]}) begin
            owc_nxt   = copy_code[3:2];
            lwc_nxt   = copy_code[1:0];
            phase_nxt = PH_COPYOFF;
          end else begin
            res_valid      = 1'b1;
            res.kind       = KIND_ERROR;
            res.error_code = ERR_BAD_CMD;
            phase_nxt      = PH_MAGIC;
          end
        end
        PH_LITLEN: begin
          acc_nxt = acc_sh;
          idx_nxt = idx_r + 3'd1;
          if (field_done(idx_r, lwc_r)) begin
            idx_nxt   = 3'd0;
            acc_nxt   = '0;
            rem_nxt   = lit_len[COUNT_WIDTH-1:0];
            phase_nxt = (lit_len == 64'd0) ? PH_CMD : PH_LITDATA;
          end
        end
        PH_LITDATA: begin
          res_valid        = 1'b1;
          res.kind         = KIND_LITERAL;
          res.literal_byte = byte_data;
          res.literal_last = rem_last;
          if (rem_last) begin
            rem_nxt   = '0;
            phase_nxt = PH_CMD;
          end else begin
            rem_nxt = rem_r - COUNT_WIDTH'(1);
          end
        end
        PH_COPYOFF: begin
          acc_nxt = acc_sh;
          idx_nxt = idx_r + 3'd1;
          if (field_done(idx_r, owc_r)) begin
            idx_nxt   = 3'd0;
            acc_nxt   = '0;
            held_nxt  = acc_sh;
            phase_nxt = PH_COPYLEN;
          end
        end
        PH_COPYLEN: begin
          acc_nxt = acc_sh;
          idx_nxt = idx_r + 3'd1;
          if (field_done(idx_r, lwc_r)) begin
            idx_nxt         = 3'd0;
            acc_nxt         = '0;
            res_valid       = 1'b1;
            res.kind        = KIND_COPY;
            res.copy_offset = held_r;
            res.copy_length = acc_sh;
            phase_nxt       = PH_CMD;
          end
        end
        default: begin
          acc_nxt   = acc_sh;
          idx_nxt   = idx_r + 3'd1;
          phase_nxt = PH_MAGIC;
          if (field_done(idx_r, MAGIC_WCODE)) begin
            idx_nxt = 3'd0;
            acc_nxt = '0;
            if (acc_sh[31:0] == MAGIC_WORD) begin
              phase_nxt = PH_CMD;
            end else begin
              res_valid      = 1'b1;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_BAD_MAGIC;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_MAGIC;
      idx_r   <= 3'd0;
      owc_r   <= 2'd0;
      lwc_r   <= 2'd0;
      acc_r   <= '0;
      held_r  <= '0;
      rem_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      owc_r   <= owc_nxt;
      lwc_r   <= lwc_nxt;
      acc_r   <= acc_nxt;
      held_r  <= held_nxt;
      rem_r   <= rem_nxt;
    end
  end

endmodule

FILE: sv/dpcd_out_reg.sv
// ----------------------------------------------------------------------------
// dpcd_out_reg
// Result register; takes a new item whenever empty or being drained.
// ----------------------------------------------------------------------------
module dpcd_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              res_valid,
  input  dpcd_pkg::result_t res,
  output logic              advance,
  dpcd_out_if.source        out_ch
);
  import dpcd_pkg::*;

  logic    valid_r;
  result_t res_r;

  assign advance             = !valid_r || out_ch.ready;
  assign out_ch.valid        = valid_r;
  assign out_ch.kind         = res_r.kind;
  assign out_ch.literal_byte = res_r.literal_byte;
  assign out_ch.literal_last = res_r.literal_last;
  assign out_ch.copy_offset  = res_r.copy_offset;
  assign out_ch.copy_length  = res_r.copy_length;
  assign out_ch.error_code   = res_r.error_code;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      res_r <= res;
    end
  end

endmodule

FILE: sv/delta_patch_command_decoder.sv
// ----------------------------------------------------------------------------
// delta_patch_command_decoder
// A byte accepted into the input register is decoded and its result is
// captured in the result register. Throughput: one byte per cycle unless the
// output stalls, set by the single-pass decoder between the two registers.
// Reset: synchronous, active low; the decoder waits for a magic word.
// ----------------------------------------------------------------------------
module delta_patch_command_decoder (
  input  logic       clk,
  input  logic       rst_n,
  dpcd_in_if.sink    in_ch,
  dpcd_out_if.source out_ch
);
  import dpcd_pkg::*;

  logic       advance;
  logic       byte_valid;
  logic [7:0] byte_data;
  logic       res_valid;
  result_t    res;

  dpcd_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .advance    (advance),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  dpcd_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (byte_valid && advance),
    .byte_data (byte_data),
    .res_valid (res_valid),
    .res       (res)
  );

  dpcd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .advance   (advance),
    .out_ch    (out_ch)
  );

endmodule
